[hdl/fcn_pkg.sv]
// shared types, constants and codes for the fractal cellular noise pixel block
package fcn_pkg;

  localparam int TABLE_SIZE  = 256;
  localparam int TAB_AW      = $clog2(TABLE_SIZE);
  localparam int MAX_OCTAVES = 8;
  localparam int OCT_W       = 4;
  localparam int K_W         = $clog2(MAX_OCTAVES);
  localparam int COORD_BITS  = 12;
  localparam int GAIN_W      = 16;
  localparam int STEP_W      = 24;
  localparam int FRAC_W      = 24;
  localparam int PROD_W      = COORD_BITS + STEP_W;
  localparam int SHIFT_W     = PROD_W + MAX_OCTAVES - 1;
  localparam int H_W         = 19;
  localparam int TOT_W       = 32;
  localparam int AMP_W       = 17;
  localparam int D_W         = 28;
  localparam int SQ_W        = 2 * D_W;
  localparam int BEST_W      = SQ_W + 1;
  localparam int V_W         = 27;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd8;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd42598;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd33554;

  localparam logic signed [H_W-1:0] H_MAX = 19'sh3FFFF;
  localparam logic signed [H_W-1:0] H_MIN = 19'sh40000;
  localparam logic [AMP_W-1:0] AMP_ONE = 17'h10000;

  // action codes
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_PIXEL  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_OCTAVES = 2'd0;
  localparam logic [1:0] REG_GAIN    = 2'd1;
  localparam logic [1:0] REG_STEP    = 2'd2;

  typedef struct packed {
    logic [1:0]            action;
    logic [TAB_AW-1:0]     table_index;
    logic [7:0]            table_value;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } item_t;

  typedef struct packed {
    logic [OCT_W-1:0]  octave_count;
    logic [GAIN_W-1:0] gain_q16;
    logic [STEP_W-1:0] base_step_q24;
  } cfg_t;

  typedef struct packed {
    logic  push;
  } qctl_t;

endpackage

[hdl/fcn_front.sv]
// front end: configuration registers and acceptance of input transactions
module fcn_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_action,
  input  logic [7:0]                     in_table_index,
  input  logic [7:0]                     in_table_value,
  input  logic [fcn_pkg::COORD_BITS-1:0] in_pixel_x,
  input  logic [fcn_pkg::COORD_BITS-1:0] in_pixel_y,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [23:0]                    cfg_data,
  input  logic                           q_full,
  output fcn_pkg::qctl_t                 qctl,
  output fcn_pkg::item_t                 q_item,
  output fcn_pkg::cfg_t                  cfg
);

  fcn_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        fcn_pkg::REG_OCTAVES: cfg_nxt.octave_count  = cfg_data[fcn_pkg::OCT_W-1:0];
        fcn_pkg::REG_GAIN:    cfg_nxt.gain_q16      = cfg_data[fcn_pkg::GAIN_W-1:0];
        fcn_pkg::REG_STEP:    cfg_nxt.base_step_q24 = cfg_data[fcn_pkg::STEP_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.octave_count  <= fcn_pkg::OCT_RESET;
      cfg_r.gain_q16      <= fcn_pkg::GAIN_RESET;
      cfg_r.base_step_q24 <= fcn_pkg::STEP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

  // unused action code is dropped here and never reaches the queue
  always_comb begin
    qctl.push = in_valid && !q_full && (in_action == fcn_pkg::ACT_LOAD ||
                in_action == fcn_pkg::ACT_PIXEL || in_action == fcn_pkg::ACT_CLEAR);
    q_item.action      = in_action;
    q_item.table_index = in_table_index;
    q_item.table_value = in_table_value;
    q_item.pixel_x     = in_pixel_x;
    q_item.pixel_y     = in_pixel_y;
  end

endmodule

[hdl/fcn_queue.sv]
// short queue between the front end and the noise engine
module fcn_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  fcn_pkg::qctl_t qctl,
  input  fcn_pkg::item_t wr_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output fcn_pkg::item_t rd_item
);

  fcn_pkg::item_t slot_r [fcn_pkg::QUEUE_DEPTH];
  logic [fcn_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [fcn_pkg::QPTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (fcn_pkg::QPTR_W+1)'(fcn_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (qctl.push ? 1'b1 : 1'b0);
    rd_ptr_nxt = rd_ptr_r + (pop ? 1'b1 : 1'b0);
    count_nxt  = count_r;
    if (qctl.push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!qctl.push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (qctl.push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

[hdl/fcn_back.sv]
// noise engine: permutation table, octave sequencer, distance unit and extremes
module fcn_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  fcn_pkg::item_t      q_item,
  output logic                q_pop,
  input  fcn_pkg::cfg_t       cfg,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [18:0]  out_height,
  output logic signed [18:0]  out_lowest,
  output logic signed [18:0]  out_highest
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_COORD = 6'b000010,
    S_CELL  = 6'b000100,
    S_OCT   = 6'b001000,
    S_DONE  = 6'b010000,
    S_MUL   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0] perm_mem [fcn_pkg::TABLE_SIZE];
  logic [7:0] rdata_r;
  logic [7:0] raddr;
  logic [7:0] t1_r, t2_r;

  logic [fcn_pkg::COORD_BITS-1:0] px_r, py_r;
  logic [fcn_pkg::PROD_W-1:0]     prodx_r, prody_r;
  logic [fcn_pkg::OCT_W-1:0]      n_r;
  logic [fcn_pkg::K_W-1:0]        k_r;
  logic [7:0]                     ix_r, iy_r;
  logic [fcn_pkg::FRAC_W-1:0]     fx_r, fy_r;
  logic [1:0]                     i_r, j_r;
  logic [2:0]                     phase_r;
  logic [7:0]                     rx_r;
  logic [fcn_pkg::SQ_W-1:0]       sqx_r, sqy_r;
  logic [fcn_pkg::BEST_W-1:0]     best_r;
  logic [fcn_pkg::AMP_W-1:0]      amp_r;
  logic signed [fcn_pkg::TOT_W-1:0] total_r;
  logic signed [18:0]             low_r, high_r;
  logic                           out_valid_r;
  logic signed [18:0]             height_r, lowest_r, highest_r;

  logic [fcn_pkg::SHIFT_W-1:0]    shx, shy;
  logic [7:0]                     cx, cy;
  logic signed [fcn_pkg::D_W-1:0] dx, dy, ioff, joff;
  logic [fcn_pkg::BEST_W-1:0]     dsum;
  logic signed [fcn_pkg::V_W-1:0] v;
  logic signed [fcn_pkg::V_W+fcn_pkg::AMP_W:0] wprod;
  logic [fcn_pkg::AMP_W+fcn_pkg::GAIN_W-1:0]  aprod;
  logic signed [18:0]             h;
  logic                           done_go, last_cell, last_oct;

  assign cx = 8'(ix_r + 8'(i_r) - 8'd1);
  assign cy = 8'(iy_r + 8'(j_r) - 8'd1);

  always_comb begin
    case (phase_r)
      3'd0:    raddr = 8'(cy + t1_r);
      3'd1:    raddr = 8'(cx + rdata_r);
      3'd2:    raddr = 8'(cy + t2_r);
      3'd3:    raddr = 8'(cx + rdata_r);
      default: raddr = 8'(cy + t1_r);
    endcase
  end

  // cell offsets of minus one, zero and plus one in Q.24
  always_comb begin
    case (i_r)
      2'd0:    ioff = -(fcn_pkg::D_W)'(32'sh100_0000);
      2'd2:    ioff = (fcn_pkg::D_W)'(32'sh100_0000);
      default: ioff = '0;
    endcase
    case (j_r)
      2'd0:    joff = -(fcn_pkg::D_W)'(32'sh100_0000);
      2'd2:    joff = (fcn_pkg::D_W)'(32'sh100_0000);
      default: joff = '0;
    endcase
    dx = $signed({4'b0, fx_r}) - ioff - $signed({4'b0, rx_r, 16'b0});
    dy = $signed({4'b0, fy_r}) - joff - $signed({4'b0, rdata_r, 16'b0});
  end

  assign shx  = (fcn_pkg::SHIFT_W)'(prodx_r) << k_r;
  assign shy  = (fcn_pkg::SHIFT_W)'(prody_r) << k_r;
  assign dsum = (fcn_pkg::BEST_W)'(sqx_r) + (fcn_pkg::BEST_W)'(sqy_r);
  assign v    = (fcn_pkg::V_W)'(32'sd65536) -
                $signed({2'b0, best_r[fcn_pkg::BEST_W-1:32]});
  assign wprod = v * $signed({1'b0, amp_r});
  assign aprod = amp_r * cfg.gain_q16;

  always_comb begin
    if (total_r > (fcn_pkg::TOT_W)'(fcn_pkg::H_MAX)) begin
      h = fcn_pkg::H_MAX;
    end else if (total_r < (fcn_pkg::TOT_W)'(fcn_pkg::H_MIN)) begin
      h = fcn_pkg::H_MIN;
    end else begin
      h = total_r[18:0];
    end
  end

  assign last_cell = (i_r == 2'd2) && (j_r == 2'd2);
  assign last_oct  = ((fcn_pkg::OCT_W)'(k_r) + 1'b1) == n_r;
  assign done_go   = !(out_valid_r && out_stall);
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid && q_item.action == fcn_pkg::ACT_PIXEL) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = (n_r == '0) ? S_DONE : S_COORD;
      S_COORD: state_nxt = S_CELL;
      S_CELL: begin
        if (phase_r == 3'd5 && last_cell) begin
          state_nxt = S_OCT;
        end
      end
      S_OCT:   state_nxt = last_oct ? S_DONE : S_COORD;
      S_DONE: begin
        if (done_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_r       <= fcn_pkg::H_MAX;
      high_r      <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_item.action == fcn_pkg::ACT_CLEAR) begin
        low_r  <= fcn_pkg::H_MAX;
        high_r <= '0;
      end
      if (state_r == S_COORD) begin
        phase_r <= '0;
      end else if (state_r == S_CELL) begin
        phase_r <= (phase_r == 3'd5) ? 3'd0 : phase_r + 3'd1;
      end
      if (state_r == S_DONE && done_go) begin
        out_valid_r <= 1'b1;
        if (h < low_r) begin
          low_r <= h;
        end
        if (h > high_r) begin
          high_r <= h;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rdata_r <= perm_mem[raddr];
    if (q_pop && q_item.action == fcn_pkg::ACT_LOAD) begin
      perm_mem[q_item.table_index] <= q_item.table_value;
      if (q_item.table_index == 8'd1) begin
        t1_r <= q_item.table_value;
      end
      if (q_item.table_index == 8'd2) begin
        t2_r <= q_item.table_value;
      end
    end
    if (q_pop && q_item.action == fcn_pkg::ACT_PIXEL) begin
      px_r    <= q_item.pixel_x;
      py_r    <= q_item.pixel_y;
      n_r     <= (cfg.octave_count > (fcn_pkg::OCT_W)'(fcn_pkg::MAX_OCTAVES)) ?
                 (fcn_pkg::OCT_W)'(fcn_pkg::MAX_OCTAVES) : cfg.octave_count;
      k_r     <= '0;
      amp_r   <= fcn_pkg::AMP_ONE;
      total_r <= '0;
    end
    if (state_r == S_MUL) begin
      prodx_r <= px_r * cfg.base_step_q24;
      prody_r <= py_r * cfg.base_step_q24;
    end
    if (state_r == S_COORD) begin
      ix_r   <= 8'(shx[31:24] + 8'(k_r) * 8'd7);
      iy_r   <= 8'(shy[31:24] + 8'(k_r) * 8'd7);
      fx_r   <= shx[fcn_pkg::FRAC_W-1:0];
      fy_r   <= shy[fcn_pkg::FRAC_W-1:0];
      best_r <= '1;
      i_r    <= '0;
      j_r    <= '0;
    end
    if (state_r == S_CELL) begin
      case (phase_r)
        3'd2: rx_r <= rdata_r;
        3'd4: begin
          sqx_r <= (fcn_pkg::SQ_W)'(dx * dx);
          sqy_r <= (fcn_pkg::SQ_W)'(dy * dy);
        end
        3'd5: begin
          if (dsum < best_r) begin
            best_r <= dsum;
          end
          if (j_r == 2'd2) begin
            j_r <= '0;
            i_r <= i_r + 2'd1;
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
    if (state_r == S_OCT) begin
      total_r <= total_r +
                 (fcn_pkg::TOT_W)'($signed(wprod[fcn_pkg::V_W+fcn_pkg::AMP_W:16]));
      amp_r   <= aprod[fcn_pkg::AMP_W+15:16];
      k_r     <= k_r + 1'b1;
    end
    if (state_r == S_DONE && done_go) begin
      height_r  <= h;
      lowest_r  <= (h < low_r) ? h : low_r;
      highest_r <= (h > high_r) ? h : high_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_height  = height_r;
  assign out_lowest  = lowest_r;
  assign out_highest = highest_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE)
    else $error("queue popped while engine busy");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= 3'd5)
    else $error("cell phase out of range");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done step");

  a_amp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OCT |-> amp_r <= fcn_pkg::AMP_ONE)
    else $error("amplitude above one");

endmodule

[hdl/fractal_cell_noise_pixel.sv]
// top level of the fractal cellular noise pixel block
//
// usage
//   input channel (in_valid / in_stall) carries one transaction per item:
//   action 0 loads one permutation table entry, action 1 computes a pixel,
//   action 2 clears the running extremes, action 3 is ignored
//   only a pixel transaction yields a result on the out_ channel, with the
//   saturated height and the running low and high after that pixel
//   configuration writes go over cfg_valid / cfg_ready (always ready) and
//   must only happen while the block is idle
// timing
//   a four-deep queue sits between the front end and the engine, so the
//   input keeps taking transactions while the engine works
//   in the engine a pixel runs a multiply step, then per octave nine cells
//   of six steps each plus two octave steps, then a done step; the cell
//   steps are set by the single read port of the permutation table (four
//   dependent table reads per cell); load and clear apply as they are popped
// reset
//   rst_n low clears control state, restores default configuration and sets
//   running low to the largest positive height and running high to zero;
//   the table contents are undefined until loaded
// stalls
//   a stalled result is held in the output register; the engine waits with
//   the next result until it is taken, and the input stalls once the queue fills
module fractal_cell_noise_pixel (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_table_value,
  input  logic [11:0]        in_pixel_x,
  input  logic [11:0]        in_pixel_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [18:0] out_height,
  output logic signed [18:0] out_lowest,
  output logic signed [18:0] out_highest,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  fcn_pkg::qctl_t qctl;
  fcn_pkg::item_t wr_item, rd_item;
  fcn_pkg::cfg_t  cfg;
  logic           q_full, q_valid, q_pop;

  // front end: config registers and transaction classification
  fcn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_full         (q_full),
    .qctl           (qctl),
    .q_item         (wr_item),
    .cfg            (cfg)
  );

  // decoupling queue
  fcn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .qctl      (qctl),
    .wr_item   (wr_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rd_item   (rd_item)
  );

  // noise engine with the output register
  fcn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (rd_item),
    .q_pop       (q_pop),
    .cfg         (cfg),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_height  (out_height),
    .out_lowest  (out_lowest),
    .out_highest (out_highest)
  );

endmodule
